// ----- sv/gwm_pkg.sv -----
// Shared types, constants and helpers for the glob wildcard matcher.
`timescale 1ns / 1ps

package gwm_pkg;

   // Pattern characters held in the configuration registers
   localparam int REG_CHARS = 16;
   localparam int CHARS_PER_REG = 4;
   localparam int PATTERN_MAX_DEFAULT = 16;

   // Character width and wildcard codes
   localparam int CHAR_W = 16;
   localparam logic [CHAR_W-1:0] STAR_CODE = 16'd42;
   localparam logic [CHAR_W-1:0] QUESTION_CODE = 16'd63;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_PAT_0_3   = 3'd0,
      CSR_PAT_4_7   = 3'd1,
      CSR_PAT_8_11  = 3'd2,
      CSR_PAT_12_15 = 3'd3,
      CSR_LENGTH    = 3'd4
   } csr_reg_type;

   // Ripple signals passed from one cell to the next
   typedef struct packed {
      logic cur_carry;   // star closure of the current live set
      logic advance;     // character consumed, next position goes live
      logic next_carry;  // star closure of the next live set
   } link_type;

   // ASCII upper case folded to lower case
   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= 16'h0041 && c <= 16'h005A) begin
         r = c + 16'h0020;
      end
      return r;
   endfunction

endpackage

// ----- sv/gwm_cell.sv -----
// One pattern position of the matcher: pattern character, live bit and ripple logic.
`timescale 1ns / 1ps

module gwm_cell import gwm_pkg::*; #(
   parameter logic START_LIVE = 1'b0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              char_we,
   input  logic [CHAR_W-1:0] char_wdata,
   input  logic              step,
   input  logic              restart,
   input  logic              active,     // position lies inside the pattern
   input  logic              in_mask,    // position not beyond the pattern end
   input  logic [CHAR_W-1:0] name_fold,
   input  link_type          link_in,
   output link_type          link_out,
   output logic              next_live
);

   logic [CHAR_W-1:0] char_ff;
   logic              live_ff;
   logic              live_in;
   logic              cur;
   logic              is_star;
   logic              is_hit;
   logic              nxt;
   logic              nxt_closed;

   // Pattern character storage
   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= '0;
      end else if (char_we) begin
         char_ff <= char_wdata;
      end
   end

   // Current set with star closure from the left
   assign cur     = (live_ff & in_mask) | link_in.cur_carry;
   assign is_star = (char_ff == STAR_CODE);
   assign is_hit  = active & cur & ~is_star &
                    ((char_ff == QUESTION_CODE) | (fold_char(char_ff) == name_fold));

   // Next set: a live star stays, a match moves right, then closure again
   assign nxt        = (cur & is_star & active) | link_in.advance;
   assign nxt_closed = nxt | link_in.next_carry;
   assign next_live  = nxt_closed;

   assign link_out.cur_carry  = cur & is_star & active;
   assign link_out.advance    = is_hit;
   assign link_out.next_carry = nxt_closed & is_star & active;

   // Live bit: back to the start set at the end of a name
   assign live_in = restart ? START_LIVE : nxt_closed;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= START_LIVE;
      end else if (step) begin
         live_ff <= live_in;
      end
   end

endmodule

// ----- sv/glob_wildcard_matcher.sv -----
// A name's result leaves on rsp_ in the cycle after its last character is taken.
// One character per cycle while no result waits untaken; each character passes through a row
// of pattern cells whose star-closure ripple across the cells sets the cycle time.
// A result waits in an output register; while it waits untaken, no character is taken.
// Synchronous reset clears the pattern, its length and the output, and makes only the start
// position live.
`timescale 1ns / 1ps

module glob_wildcard_matcher import gwm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   // name character stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [CHAR_W-1:0] req_tdata,   // [15:0] name_char
   input  logic              req_tlast,   // name_last
   // match results
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [7:0]        rsp_tdata,   // [0] is_match, [7:1] zero
   // configuration writes
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [63:0]       csr_data
);

   localparam int CELLS = (PATTERN_MAX < REG_CHARS) ? PATTERN_MAX : REG_CHARS;
   localparam int LEN_W = $clog2(CELLS + 1);

   logic              req_fire;
   logic              csr_fire;
   logic [4:0]        pattern_length_ff;
   logic [LEN_W-1:0]  len_used;
   logic [CHAR_W-1:0] name_fold;
   logic [CELLS-1:0]  active;
   logic [CELLS-1:0]  in_mask;
   logic [CELLS:0]    next_set;
   link_type          link [0:CELLS];
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              rsp_match_ff;

   assign req_fire  = req_tvalid & req_tready;
   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid & csr_ready;

   // Pattern length register
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_length_ff <= '0;
      end else if (csr_fire && csr_index == CSR_LENGTH) begin
         pattern_length_ff <= csr_data[4:0];
      end
   end

   // Length in use, saturated to the number of cells
   always_comb begin
      if ({1'b0, pattern_length_ff} > 6'(CELLS)) begin
         len_used = LEN_W'(CELLS);
      end else begin
         len_used = pattern_length_ff[LEN_W-1:0];
      end
   end

   assign name_fold = fold_char(req_tdata);
   assign link[0]   = '0;

   // Row of pattern cells
   for (genvar i = 0; i < CELLS; i++) begin : g_cell
      logic char_we;

      assign active[i]  = (len_used > LEN_W'(i));
      assign in_mask[i] = (len_used >= LEN_W'(i));
      assign char_we    = csr_fire && (csr_index <= CSR_PAT_12_15) &&
                          (csr_index[1:0] == 2'(i / CHARS_PER_REG));

      gwm_cell #(
         .START_LIVE (1'(i == 0))
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .char_we    (char_we),
         .char_wdata (csr_data[CHAR_W*(i % CHARS_PER_REG) +: CHAR_W]),
         .step       (req_fire),
         .restart    (req_tlast),
         .active     (active[i]),
         .in_mask    (in_mask[i]),
         .name_fold  (name_fold),
         .link_in    (link[i]),
         .link_out   (link[i+1]),
         .next_live  (next_set[i])
      );
   end

   // Position past the last cell: reached by a match or a trailing star
   assign next_set[CELLS] = link[CELLS].advance | link[CELLS].next_carry;

   // Output register; a waiting result that is not taken holds off the input
   assign req_tready = ~rsp_valid_ff | rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_fire && req_tlast) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_match_ff <= 1'b0;
      end else if (req_fire && req_tlast) begin
         rsp_match_ff <= next_set[len_used];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_match_ff};

   // A name's last character always yields a result in the next cycle
   a_last_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast |=> rsp_tvalid)
      else $error("no result after last character");

   // Characters inside a name never create or drop a result
   a_inner_no_result: assert property (@(posedge clock) disable iff (reset)
      req_fire && !req_tlast && !(rsp_tvalid && rsp_tready) |=> $stable(rsp_tvalid))
      else $error("result changed by an inner character");

   // An empty pattern matches no name
   a_empty_no_match: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_tlast && (len_used == '0) |=> !rsp_tdata[0])
      else $error("empty pattern reported a match");

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the glob wildcard matcher: directed and random names.
`timescale 1ns / 1ps

module tb import gwm_pkg::*; ();

   localparam int LEN_CAP = (PATTERN_MAX_DEFAULT < REG_CHARS) ? PATTERN_MAX_DEFAULT : REG_CHARS;
   localparam int RANDOM_ITEMS = 400;
   localparam int NAMES_PER_PATTERN = 8;
   localparam int SETTLE_CYCLES = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS = 10;
   localparam logic [2:0] CSR_INDEX_TOP = 3'd7;
   localparam logic [CHAR_W-1:0] UPPER_A = 16'h0041;
   localparam logic [CHAR_W-1:0] UPPER_Z = 16'h005A;
   localparam logic [CHAR_W-1:0] LOWER_A = 16'h0061;
   localparam logic [CHAR_W-1:0] LOWER_Z = 16'h007A;
   localparam logic [CHAR_W-1:0] CASE_GAP = 16'h0020;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [CHAR_W-1:0] req_tdata;   // [15:0] name_char
   logic              req_tlast;   // name_last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [7:0]        rsp_tdata;   // [0] is_match, [7:1] zero
   logic              csr_valid;
   logic              csr_ready;
   logic [2:0]        csr_index;
   logic [63:0]       csr_data;

   // Matcher model: pattern copy, length and live position set
   logic [CHAR_W-1:0] pat_char [REG_CHARS];
   logic [4:0]        pat_len;
   logic [REG_CHARS:0] live_set;

   // Match bits still owed by the block, oldest first
   logic              match_due [$];
   logic [CHAR_W-1:0] name_buf [$];

   int send_gap_pct;
   int recv_stall_pct;
   int error_count = 0;
   int chars_sent = 0;
   int idle_cycles = 0;
   logic due_bit;

   glob_wildcard_matcher i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic logic [CHAR_W-1:0] lower_case(input logic [CHAR_W-1:0] ch);
      return (ch >= UPPER_A && ch <= UPPER_Z) ? ch + CASE_GAP : ch;
   endfunction

   function automatic int used_len();
      return (int'(pat_len) > LEN_CAP) ? LEN_CAP : int'(pat_len);
   endfunction

   // a live star also makes the following position live; ripples left to right
   function automatic logic [REG_CHARS:0] star_close(input logic [REG_CHARS:0] set,
                                                     input int len);
      for (int i = 0; i < len; i++)
         if (set[i] && pat_char[i] == STAR_CODE) set[i+1] = 1'b1;
      return set;
   endfunction

   function automatic logic [REG_CHARS:0] next_live(input logic [CHAR_W-1:0] ch);
      int len;
      logic [REG_CHARS:0] cur;
      logic [REG_CHARS:0] nxt;
      logic [CHAR_W-1:0] c;
      len = used_len();
      c = lower_case(ch);
      // positions past the length in use are dropped
      cur = '0;
      for (int i = 0; i <= len; i++) cur[i] = live_set[i];
      cur = star_close(cur, len);
      nxt = '0;
      for (int i = 0; i < len; i++) begin
         if (cur[i]) begin
            if (pat_char[i] == STAR_CODE) nxt[i] = 1'b1;
            else if (pat_char[i] == QUESTION_CODE || lower_case(pat_char[i]) == c)
               nxt[i+1] = 1'b1;
         end
      end
      return star_close(nxt, len);
   endfunction

   // ---------------------------------------------------------------- drivers

   task automatic note_error(input string msg);
      if (error_count < MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // one character transaction; the model advances when it is taken
   task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
      logic [REG_CHARS:0] nxt;
      @(negedge clock);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = ch;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      chars_sent++;
      nxt = next_live(ch);
      if (last) begin
         match_due.push_back(nxt[used_len()]);
         live_set = 1;
      end else begin
         live_set = nxt;
      end
   endtask

   task automatic send_name();
      for (int i = 0; i < name_buf.size(); i++)
         send_char(name_buf[i], i == name_buf.size() - 1);
   endtask

   task automatic send_text(input string s);
      name_buf.delete();
      for (int i = 0; i < s.len(); i++) name_buf.push_back({8'd0, s[i]});
      send_name();
   endtask

   // stop sending, let every owed result drain, then give the block time to settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (match_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [63:0] value);
      int base;
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx <= CSR_PAT_12_15) begin
         base = int'(idx - CSR_PAT_0_3) * CHARS_PER_REG;
         for (int k = 0; k < CHARS_PER_REG; k++) pat_char[base + k] = value[16*k +: 16];
      end else if (idx == CSR_LENGTH) begin
         pat_len = value[4:0];
      end
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // chars: character 0 in the lowest 16 bits
   task automatic load_pattern(input logic [255:0] chars, input logic [4:0] len);
      wait_idle();
      for (int k = 0; k < 4; k++)
         write_csr(csr_reg_type'(CSR_PAT_0_3 + k), chars[64*k +: 64]);
      write_csr(CSR_LENGTH, {59'd0, len});
   endtask

   function automatic logic [255:0] pack_text(input string s);
      logic [255:0] r;
      r = '0;
      for (int i = 0; i < s.len(); i++) r[16*i +: 16] = {8'd0, s[i]};
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] rand_name_char();
      case ($urandom_range(9, 0))
         0:       return CHAR_W'($urandom_range(16'hFFFF, 0));
         1:       return STAR_CODE;
         2:       return QUESTION_CODE;
         3, 4, 5: return LOWER_A + CHAR_W'($urandom_range(2, 0));
         default: return UPPER_A + CHAR_W'($urandom_range(2, 0));
      endcase
   endfunction

   function automatic logic [CHAR_W-1:0] rand_pattern_char();
      case ($urandom_range(9, 0))
         0, 1, 2: return STAR_CODE;
         3:       return QUESTION_CODE;
         4:       return CHAR_W'($urandom_range(16'hFFFF, 0));
         5:       return UPPER_A + CHAR_W'($urandom_range(2, 0));
         default: return LOWER_A + CHAR_W'($urandom_range(2, 0));
      endcase
   endfunction

   // ---------------------------------------------------------------- result check

   always @(negedge clock) rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (match_due.size() == 0) begin
            note_error($sformatf("result 0x%02h with none owed", rsp_tdata));
         end else begin
            due_bit = match_due.pop_front();
            if (rsp_tdata !== {7'd0, due_bit})
               note_error($sformatf("is_match: expected %0b, got tdata 0x%02h",
                                    due_bit, rsp_tdata));
         end
      end
   end

   // watchdog on cycles with no transaction on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- tests

   // reset pattern is empty and matches nothing
   task automatic test_empty_pattern();
      send_text("a");
      load_pattern(pack_text("abc"), 5'd0);
      send_text("Z");
   endtask

   // literals with case folding on both sides
   task automatic test_literal_fold();
      load_pattern(pack_text("aB"), 5'd2);
      send_text("Ab");
      send_text("ac");
   endtask

   // star over an empty run, question mark needing a character at the end
   task automatic test_star_question();
      load_pattern(pack_text("a*?"), 5'd3);
      send_text("ab");
      send_text("a");
      send_text("a**x");
   endtask

   // zero and all-ones characters as literals
   task automatic test_char_extremes();
      load_pattern(256'hFFFF_0000, 5'd2);
      name_buf = '{16'h0000, 16'hFFFF};
      send_name();
      name_buf = '{16'hFFFF};
      send_name();
   endtask

   // length past the register slots saturates; top register all ones
   task automatic test_long_length();
      logic [255:0] stars;
      stars = '0;
      for (int i = 0; i < REG_CHARS; i++) stars[16*i +: 16] = STAR_CODE;
      load_pattern(stars, 5'd31);
      send_text("x");
      wait_idle();
      write_csr(CSR_PAT_12_15, '1);
      write_csr(CSR_LENGTH, 64'd16);
      send_text("q");
   endtask

   // pattern rewritten while a name is half way through
   task automatic test_mid_name_change();
      logic [255:0] text;
      load_pattern(pack_text("ab"), 5'd2);
      send_char(16'h0061, 1'b0);
      wait_idle();
      text = pack_text("ac");
      write_csr(CSR_PAT_0_3, text[63:0]);
      send_char(16'h0043, 1'b1);
      send_char(16'h0061, 1'b0);
      wait_idle();
      write_csr(CSR_LENGTH, 64'd1);
      send_char(16'h0063, 1'b1);
   endtask

   // writes to unused indexes leave the pattern alone
   task automatic test_unused_index();
      wait_idle();
      for (int k = CSR_LENGTH + 1; k <= CSR_INDEX_TOP; k++)
         write_csr(3'(k), {$urandom, $urandom});
      send_text("a");
   endtask

   task automatic load_random_pattern();
      logic [255:0] chars;
      logic [4:0] len;
      for (int i = 0; i < REG_CHARS; i++) chars[16*i +: 16] = rand_pattern_char();
      case ($urandom_range(9, 0))
         0:       len = 5'd0;
         1:       len = 5'($urandom_range(31, 17));
         2:       len = 5'd16;
         default: len = 5'($urandom_range(8, 1));
      endcase
      load_pattern(chars, len);
      if ($urandom_range(3, 0) == 0)
         write_csr(3'($urandom_range(CSR_INDEX_TOP, CSR_LENGTH + 1)), {$urandom, $urandom});
   endtask

   // mostly names built to fit the pattern, some spoilt, the rest noise
   task automatic build_name();
      int kind;
      logic [CHAR_W-1:0] p;
      name_buf.delete();
      kind = $urandom_range(99, 0);
      if (kind < 65) begin
         for (int i = 0; i < used_len(); i++) begin
            p = pat_char[i];
            if (p == STAR_CODE) begin
               repeat ($urandom_range(3, 0)) name_buf.push_back(rand_name_char());
            end else if (p == QUESTION_CODE) begin
               name_buf.push_back(rand_name_char());
            end else begin
               if ($urandom_range(1, 0) && p >= LOWER_A && p <= LOWER_Z) p = p - CASE_GAP;
               else if ($urandom_range(1, 0) && p >= UPPER_A && p <= UPPER_Z) p = p + CASE_GAP;
               name_buf.push_back(p);
            end
         end
         if (kind >= 50) begin
            if (name_buf.size() > 1 && $urandom_range(1, 0)) void'(name_buf.pop_back());
            else name_buf.push_back(rand_name_char());
         end
      end else begin
         repeat ($urandom_range(8, 1)) name_buf.push_back(rand_name_char());
      end
      if (name_buf.size() == 0) name_buf.push_back(rand_name_char());
   endtask

   task automatic test_random_names();
      int start;
      int names;
      start = chars_sent;
      names = 0;
      while (chars_sent - start < RANDOM_ITEMS) begin
         // idling profile by thirds of the run
         if (chars_sent - start >= 2 * RANDOM_ITEMS / 3) begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end else if (chars_sent - start >= RANDOM_ITEMS / 3) begin
            send_gap_pct = 70;
            recv_stall_pct = 37;
         end
         if (names % NAMES_PER_PATTERN == 0) load_random_pattern();
         build_name();
         send_name();
         names++;
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_PAT_0_3;
      csr_data = '0;
      for (int i = 0; i < REG_CHARS; i++) pat_char[i] = '0;
      pat_len = '0;
      live_set = 1;
      send_gap_pct = 37;
      recv_stall_pct = 70;
      repeat (5) @(negedge clock);
      reset = 1'b0;

      test_empty_pattern();
      test_literal_fold();
      test_star_question();
      test_char_extremes();
      test_long_length();
      test_mid_name_change();
      test_unused_index();
      test_random_names();

      wait_idle();
      if (error_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
